[rtl/lsq_pkg.sv]
// Shared types, widths, codes and the control store of the LED pattern sequencer.
`timescale 1ns / 1ps

package lsq_pkg;

   localparam int LED_COUNT_DEF   = 8;
   localparam int TABLE_DEPTH_DEF = 64;

   localparam int MODE_W        = 2;
   localparam int ENTRY_INDEX_W = 6;
   localparam int COLOR_W       = 24;
   localparam int LED_INDEX_W   = 3;
   localparam int LENGTH_W      = 7;
   localparam int OFFSET_W      = 6;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 7;

   localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LED_OFFSET     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATIC_PATTERN = 2'd2;

   // Control store addresses
   typedef enum logic [2:0] {
      STEP_IDLE    = 3'd0,
      STEP_SETUP   = 3'd1,
      STEP_REDUCE  = 3'd2,
      STEP_INIT    = 3'd3,
      STEP_PRIME   = 3'd4,
      STEP_EMIT    = 3'd5,
      STEP_ADVANCE = 3'd6
   } step_type;

   // Jump conditions: stay on the step until the condition holds, then go to target
   typedef enum logic [1:0] {
      JMP_ALWAYS = 2'd0,
      JMP_FRAME  = 2'd1,
      JMP_COUNT  = 2'd2,
      JMP_LAST   = 2'd3
   } jump_type;

   typedef struct packed {
      logic     take;
      logic     setup;
      logic     reduce;
      logic     init;
      logic     fetch;
      logic     emit;
      logic     advance;
      jump_type jump;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic frame_go;
      logic count_done;
      logic last_fire;
   } stat_type;

   function automatic ctrl_type ucode(input step_type step);
      ctrl_type w;
      w = '{take: 1'b0, setup: 1'b0, reduce: 1'b0, init: 1'b0, fetch: 1'b0,
            emit: 1'b0, advance: 1'b0, jump: JMP_ALWAYS, target: STEP_IDLE};
      unique case (step)
         STEP_IDLE: begin
            w.take   = 1'b1;
            w.jump   = JMP_FRAME;
            w.target = STEP_SETUP;
         end
         STEP_SETUP: begin
            w.setup  = 1'b1;
            w.target = STEP_REDUCE;
         end
         STEP_REDUCE: begin
            w.reduce = 1'b1;
            w.jump   = JMP_COUNT;
            w.target = STEP_INIT;
         end
         STEP_INIT: begin
            w.init   = 1'b1;
            w.target = STEP_PRIME;
         end
         STEP_PRIME: begin
            w.fetch  = 1'b1;
            w.target = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit   = 1'b1;
            w.jump   = JMP_LAST;
            w.target = STEP_ADVANCE;
         end
         STEP_ADVANCE: begin
            w.advance = 1'b1;
            w.target  = STEP_IDLE;
         end
         default: begin
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

[rtl/led_pattern_sequencer.sv]
// LED pattern sequencer: a microcoded player of a colour table onto an LED strip.
// A load transaction leaves the block idle; a tick or restart transaction occupies it
// until its frame is out: the remainder loop runs one step per bit, then one LED
// per cycle leaves through the output register while the receiver does not stall.
// Synchronous active-high reset clears the position and loads the register defaults;
// the colour table is not cleared and reads as undefined until written.
`timescale 1ns / 1ps

module led_pattern_sequencer import lsq_pkg::*; #(
   parameter int LED_COUNT   = LED_COUNT_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic [ENTRY_INDEX_W-1:0] req_entry_index,
   input  logic [COLOR_W-1:0]       req_entry_color,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [LED_INDEX_W-1:0]   rsp_led_index,
   output logic [COLOR_W-1:0]       rsp_led_color,
   output logic                     rsp_frame_last,
   input  logic                     csr_write,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int PW = $clog2(TABLE_DEPTH);
   localparam logic [LENGTH_W-1:0] LEN_CAP =
      (TABLE_DEPTH < 127) ? LENGTH_W'(TABLE_DEPTH) : LENGTH_W'(127);

   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                static_ff, static_in;
   logic [LENGTH_W-1:0] length_eff;

   ctrl_type           ctrl;
   stat_type           stat;
   logic               req_take;
   logic               wr_en;
   logic               rd_en;
   logic [PW-1:0]      rd_addr;
   logic [COLOR_W-1:0] rd_data;
   logic               count_done;
   logic               last_fire;

   always_comb begin
      length_in = length_ff;
      offset_in = offset_ff;
      static_in = static_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: length_in = csr_data[LENGTH_W-1:0];
            CSR_LED_OFFSET:     offset_in = csr_data[OFFSET_W-1:0];
            CSR_STATIC_PATTERN: static_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LENGTH_W'(1);
         offset_ff <= '0;
         static_ff <= 1'b1;
      end else begin
         length_ff <= length_in;
         offset_ff <= offset_in;
         static_ff <= static_in;
      end
   end

   // Clamp the length into 1 .. min(table depth, 127)
   always_comb begin
      priority if (length_ff == '0) begin
         length_eff = LENGTH_W'(1);
      end else if (length_ff > LEN_CAP) begin
         length_eff = LEN_CAP;
      end else begin
         length_eff = length_ff;
      end
   end

   assign req_stall = !ctrl.take;
   assign req_take  = req_valid && ctrl.take;
   assign wr_en     = req_take && (req_mode == MODE_LOAD)
                      && (32'(req_entry_index) < TABLE_DEPTH);

   assign stat.frame_go   = req_take
                            && ((req_mode == MODE_TICK) || (req_mode == MODE_RESTART));
   assign stat.count_done = count_done;
   assign stat.last_fire  = last_fire;

   lsq_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   lsq_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (PW'(req_entry_index)),
      .wr_data (req_entry_color),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lsq_datapath #(
      .LED_COUNT   (LED_COUNT),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .frame_go       (stat.frame_go),
      .restart        (req_mode == MODE_RESTART),
      .length         (length_eff),
      .offset         (offset_ff),
      .static_mode    (static_ff),
      .count_done     (count_done),
      .last_fire      (last_fire),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_led_index  (rsp_led_index),
      .rsp_led_color  (rsp_led_color),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

[rtl/lsq_seq.sv]
// Step counter and control store lookup of the LED pattern sequencer.
`timescale 1ns / 1ps

module lsq_seq import lsq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctrl_type ctrl
);

   step_type step_ff;
   step_type step_in;
   logic     go;

   assign ctrl = ucode(step_ff);

   always_comb begin
      unique case (ctrl.jump)
         JMP_ALWAYS: go = 1'b1;
         JMP_FRAME:  go = stat.frame_go;
         JMP_COUNT:  go = stat.count_done;
         JMP_LAST:   go = stat.last_fire;
         default:    go = 1'b1;
      endcase
      step_in = go ? ctrl.target : step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

[rtl/lsq_table.sv]
// Colour table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module lsq_table import lsq_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   localparam int PW = $clog2(TABLE_DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [PW-1:0]      wr_addr,
   input  logic [COLOR_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [PW-1:0]      rd_addr,
   output logic [COLOR_W-1:0] rd_data
);

   logic [COLOR_W-1:0] table_ff [TABLE_DEPTH];
   logic [COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lsq_datapath.sv]
// Position, remainder, table address and output register datapath.
`timescale 1ns / 1ps

module lsq_datapath import lsq_pkg::*; #(
   parameter int LED_COUNT   = LED_COUNT_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   localparam int PW = $clog2(TABLE_DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_type               ctrl,
   input  logic                   frame_go,
   input  logic                   restart,
   input  logic [LENGTH_W-1:0]    length,
   input  logic [OFFSET_W-1:0]    offset,
   input  logic                   static_mode,
   output logic                   count_done,
   output logic                   last_fire,
   output logic                   rd_en,
   output logic [PW-1:0]          rd_addr,
   input  logic [COLOR_W-1:0]     rd_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [LED_INDEX_W-1:0] rsp_led_index,
   output logic [COLOR_W-1:0]     rsp_led_color,
   output logic                   rsp_frame_last
);

   localparam int PW1 = PW + 1;
   localparam int DW  = (PW > OFFSET_W) ? PW : OFFSET_W;
   localparam int SW  = DW + LENGTH_W;
   localparam int KW  = $clog2(DW);
   localparam int CW  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   logic [PW-1:0]          pos_ff, pos_in;
   logic [DW-1:0]          rem_a_ff, rem_a_in;
   logic [DW-1:0]          rem_b_ff, rem_b_in;
   logic [KW-1:0]          k_ff, k_in;
   logic [PW-1:0]          acc_ff, acc_in;
   logic [CW-1:0]          led_ff, led_in;
   logic                   valid_ff, valid_in;
   logic [LED_INDEX_W-1:0] index_ff, index_in;
   logic [COLOR_W-1:0]     color_ff, color_in;
   logic                   last_ff, last_in;

   logic [SW-1:0]  div_sh;
   logic [PW1-1:0] len_p;
   logic [PW1-1:0] acc_sum;
   logic [PW1-1:0] pos_nxt;
   logic           led_last;
   logic           emit_fire;

   assign div_sh    = SW'(length) << k_ff;
   assign len_p     = PW1'(length);
   assign acc_sum   = PW1'(acc_ff) + PW1'(rem_b_ff[PW-1:0]);
   assign pos_nxt   = PW1'(rem_a_ff[PW-1:0]) + PW1'(1);
   assign led_last  = (led_ff == CW'(LED_COUNT - 1));
   assign emit_fire = ctrl.emit && (!valid_ff || !rsp_stall);

   assign count_done = (k_ff == '0);
   assign last_fire  = emit_fire && led_last;
   assign rd_en      = ctrl.fetch || (emit_fire && !led_last);
   assign rd_addr    = acc_ff;

   always_comb begin
      pos_in   = pos_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      led_in   = led_ff;
      valid_in = valid_ff && rsp_stall;
      index_in = index_ff;
      color_in = color_ff;
      last_in  = last_ff;

      if (frame_go && restart) begin
         pos_in = '0;
      end
      if (ctrl.setup) begin
         rem_a_in = DW'(pos_ff);
         rem_b_in = static_mode ? DW'(1) : DW'(offset);
         k_in     = KW'(DW - 1);
      end
      // Restoring remainder: one shifted length per step, both operands together
      if (ctrl.reduce) begin
         if (SW'(rem_a_ff) >= div_sh) begin
            rem_a_in = rem_a_ff - div_sh[DW-1:0];
         end
         if (SW'(rem_b_ff) >= div_sh) begin
            rem_b_in = rem_b_ff - div_sh[DW-1:0];
         end
         if (k_ff != '0) begin
            k_in = k_ff - KW'(1);
         end
      end
      if (ctrl.init) begin
         acc_in = static_mode ? '0 : rem_a_ff[PW-1:0];
         led_in = '0;
      end
      // Step the table address, wrapping once at the length
      if (rd_en) begin
         acc_in = (acc_sum >= len_p) ? PW'(acc_sum - len_p) : acc_sum[PW-1:0];
      end
      if (emit_fire) begin
         valid_in = 1'b1;
         index_in = LED_INDEX_W'(led_ff);
         color_in = rd_data;
         last_in  = led_last;
         if (!led_last) begin
            led_in = led_ff + CW'(1);
         end
      end
      if (ctrl.advance) begin
         pos_in = (pos_nxt == len_p) ? '0 : pos_nxt[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         k_ff     <= '0;
         led_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         k_ff     <= k_in;
         led_ff   <= led_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
      acc_ff   <= acc_in;
      index_ff <= index_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_led_index  = index_ff;
   assign rsp_led_color  = color_ff;
   assign rsp_frame_last = last_ff;

endmodule

[sim/led_pattern_sequencer_test.sv]
// Self-checking testbench of the LED pattern sequencer: directed and random frames.
`timescale 1ns / 1ps

module led_pattern_sequencer_test;
   import lsq_pkg::*;

   localparam int LEDS          = LED_COUNT_DEF;
   localparam int DEPTH         = TABLE_DEPTH_DEF;
   localparam int SETTLE_CYCLES = 30;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 300;

   localparam logic [MODE_W-1:0]      MODE_SPARE = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE  = 2'd3;

   typedef struct packed {
      logic [LED_INDEX_W-1:0] led;
      logic [COLOR_W-1:0]     colour;
      logic                   last;
   } led_beat_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [MODE_W-1:0]        req_mode;
   logic [ENTRY_INDEX_W-1:0] req_entry_index;
   logic [COLOR_W-1:0]       req_entry_color;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [LED_INDEX_W-1:0]   rsp_led_index;
   logic [COLOR_W-1:0]       rsp_led_color;
   logic                     rsp_frame_last;
   logic                     csr_write;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]    csr_data;

   // predictor state
   logic [COLOR_W-1:0]  colour_table [DEPTH];
   logic [OFFSET_W-1:0] strip_position = '0;
   logic [LENGTH_W-1:0] length_reg     = 7'd1;
   logic [OFFSET_W-1:0] offset_reg     = '0;
   logic                static_reg     = 1'b1;

   led_beat_type expected_leds[$];
   int           mismatch_count = 0;
   int           quiet_cycles   = 0;
   int           stall_left     = 0;
   bit           idling_on      = 1'b1;

   led_pattern_sequencer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_entry_index (req_entry_index),
      .req_entry_color (req_entry_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_led_index   (rsp_led_index),
      .rsp_led_color   (rsp_led_color),
      .rsp_frame_last  (rsp_frame_last),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #10 clock = ~clock;

   function automatic int strip_length();
      if (length_reg == 0) return 1;
      if (length_reg > DEPTH) return DEPTH;
      return int'(length_reg);
   endfunction

   // Work out the effect of one accepted transaction and queue the LED colours it yields.
   function automatic void predict_strip(input logic [MODE_W-1:0] mode,
                                         input logic [ENTRY_INDEX_W-1:0] index,
                                         input logic [COLOR_W-1:0] colour);
      int           len;
      int           pick;
      led_beat_type beat;
      if (mode == MODE_LOAD) begin
         colour_table[index] = colour;
      end else if (mode == MODE_TICK || mode == MODE_RESTART) begin
         if (mode == MODE_RESTART) strip_position = '0;
         len = strip_length();
         for (int i = 0; i < LEDS; i++) begin
            if (static_reg) pick = i % len;
            else pick = (int'(strip_position) + i * int'(offset_reg)) % len;
            beat.led    = i[LED_INDEX_W-1:0];
            beat.colour = colour_table[pick];
            beat.last   = (i == LEDS - 1);
            expected_leds.push_back(beat);
         end
         strip_position = OFFSET_W'((int'(strip_position) + 1) % len);
      end
   endfunction

   always @(posedge clock) begin : check_leds
      led_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_leds.size() == 0) begin
            $error("unexpected LED result: led_index %0d led_color %06h",
                   rsp_led_index, rsp_led_color);
            mismatch_count++;
         end else begin
            want = expected_leds.pop_front();
            if (rsp_led_index !== want.led) begin
               $error("led_index: expected %0d, got %0d", want.led, rsp_led_index);
               mismatch_count++;
            end
            if (rsp_led_color !== want.colour) begin
               $error("led_color: expected %06h, got %06h", want.colour, rsp_led_color);
               mismatch_count++;
            end
            if (rsp_frame_last !== want.last) begin
               $error("frame_last: expected %0b, got %0b", want.last, rsp_frame_last);
               mismatch_count++;
            end
         end
      end
   end

   // receiver stalls in random bursts while idling is on
   always @(posedge clock) begin
      if (!idling_on) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Offer one transaction and hold it until taken; valid stays high for the caller.
   task automatic send_item(input logic [MODE_W-1:0] mode,
                            input logic [ENTRY_INDEX_W-1:0] index,
                            input logic [COLOR_W-1:0] colour);
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_entry_index <= index;
      req_entry_color <= colour;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_strip(mode, index, colour);
   endtask

   // Drop valid and wait until every LED colour is out and the block has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_leds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      case (index)
         CSR_PATTERN_LENGTH: length_reg = data;
         CSR_LED_OFFSET:     offset_reg = data[OFFSET_W-1:0];
         CSR_STATIC_PATTERN: static_reg = data[0];
         default: ;
      endcase
   endtask

   task automatic write_registers(input logic [CSR_DATA_W-1:0] length,
                                  input logic [CSR_DATA_W-1:0] offset,
                                  input logic [CSR_DATA_W-1:0] still);
      write_csr(CSR_PATTERN_LENGTH, length);
      write_csr(CSR_LED_OFFSET, offset);
      write_csr(CSR_STATIC_PATTERN, still);
      csr_write <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_item(MODE_LOAD, 6'd0, 24'hFFFFFF);
      send_item(MODE_LOAD, 6'd63, 24'h000000);
      for (int i = 1; i < LEDS; i++)
         send_item(MODE_LOAD, ENTRY_INDEX_W'(i), COLOR_W'($urandom()));
      send_item(MODE_TICK, 6'd0, 24'd0);
      send_item(MODE_RESTART, 6'd63, 24'hFFFFFF);
      // spare mode must leave the table alone
      send_item(MODE_SPARE, 6'd0, 24'h000000);
      send_item(MODE_TICK, ENTRY_INDEX_W'($urandom()), COLOR_W'($urandom()));
      wait_idle();
   endtask

   task automatic test_position_wrap();
      write_registers(7'd0, 7'd63, 7'd0);
      send_item(MODE_RESTART, 6'd0, 24'd0);
      send_item(MODE_TICK, 6'd0, 24'd0);
      wait_idle();
      write_registers(7'd5, 7'd3, 7'd0);
      repeat (3) send_item(MODE_TICK, 6'd0, 24'd0);
      wait_idle();
      // shorten the length below the current position
      write_csr(CSR_PATTERN_LENGTH, 7'd2);
      write_csr(CSR_LED_OFFSET, 7'd1);
      write_csr(CSR_STATIC_PATTERN, 7'd0);
      write_csr(CSR_SPARE, 7'h7F);
      csr_write <= 1'b0;
      send_item(MODE_TICK, 6'd0, 24'd0);
      send_item(MODE_TICK, 6'd0, 24'd0);
      wait_idle();
   endtask

   task automatic test_table_fill();
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0) send_item(MODE_LOAD, 6'd0, 24'h000000);
         else if (i == DEPTH - 1) send_item(MODE_LOAD, ENTRY_INDEX_W'(i), 24'hFFFFFF);
         else send_item(MODE_LOAD, ENTRY_INDEX_W'(i), COLOR_W'($urandom()));
      end
      wait_idle();
   endtask

   task automatic test_length_saturation();
      write_registers(7'd127, 7'd1, 7'd0);
      send_item(MODE_RESTART, 6'd0, 24'd0);
      send_item(MODE_TICK, 6'd0, 24'd0);
      wait_idle();
      write_registers(7'd65, 7'h7F, 7'h7E);
      send_item(MODE_TICK, 6'd0, 24'd0);
      send_item(MODE_TICK, 6'd0, 24'd0);
      wait_idle();
      write_registers(7'd64, 7'd63, 7'h7F);
      send_item(MODE_TICK, 6'd0, 24'd0);
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int                  sent;
      int                  burst;
      int                  roll;
      logic [CSR_DATA_W-1:0] length;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 5);
         case (roll)
            0: length = 7'd0;
            1: length = 7'd127;
            2: length = 7'd64;
            3: length = CSR_DATA_W'($urandom_range(65, 126));
            default: length = CSR_DATA_W'($urandom_range(1, 64));
         endcase
         write_registers(length, CSR_DATA_W'($urandom_range(0, 127)),
                         CSR_DATA_W'($urandom_range(0, 127)));
         // the closing stretch runs without any idling
         idling_on = (sent < RANDOM_ITEMS - 40) && ($urandom_range(0, 3) != 0);
         burst = $urandom_range(10, 30);
         for (int n = 0; n < burst; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
               send_item(MODE_LOAD, ENTRY_INDEX_W'($urandom()), COLOR_W'($urandom()));
               sent++;
            end else if (roll < 27) begin
               send_item(MODE_RESTART, ENTRY_INDEX_W'($urandom()), COLOR_W'($urandom()));
               sent++;
            end else if (roll < 32) begin
               send_item(MODE_SPARE, ENTRY_INDEX_W'($urandom()), COLOR_W'($urandom()));
            end else begin
               send_item(MODE_TICK, ENTRY_INDEX_W'($urandom()), COLOR_W'($urandom()));
               sent++;
            end
            if ($urandom_range(0, 49) == 0) wait_idle();
         end
         wait_idle();
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_mode        <= MODE_LOAD;
      req_entry_index <= '0;
      req_entry_color <= '0;
      csr_write       <= 1'b0;
      csr_index       <= CSR_PATTERN_LENGTH;
      csr_data        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_position_wrap();
      test_table_fill();
      test_length_saturation();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0 && expected_leds.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
